[rtl/ucc_pkg.sv]
`timescale 1ns / 1ps
package ucc_pkg;

   localparam int PointWidth = 31;
   localparam int DiffWidth  = 32;
   localparam int LenWidth   = 3;

   localparam logic [1:0] ACT_FIRST  = 2'd0;
   localparam logic [1:0] ACT_SECOND = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   localparam logic [1:0] CONT_TAG = 2'b10;
   localparam logic [7:0] LEAD_TWO = 8'hC0;
   localparam logic [7:0] LEAD_MULTI = 8'hE0;

   localparam logic [DiffWidth-1:0] MINUS_ONE = {DiffWidth{1'b1}};
   localparam logic [DiffWidth-1:0] PLUS_ONE  = {{(DiffWidth-1){1'b0}}, 1'b1};

   typedef struct packed {
      logic [LenWidth-1:0]   len;
      logic                  single;
      logic [PointWidth-1:0] point;
   } lead_type;

   // Length of a character whose lead byte is 0xE0 or above, by its low five bits.
   function automatic logic [LenWidth-1:0] high_len(input logic [4:0] idx);
      logic [LenWidth-1:0] len;
      unique case (idx) inside
         [5'd0:5'd15]:  len = 3'd3;
         [5'd16:5'd23]: len = 3'd4;
         [5'd24:5'd27]: len = 3'd5;
         default:       len = 3'd6;
      endcase
      return len;
   endfunction

endpackage

[rtl/ucc_decode.sv]
`timescale 1ns / 1ps
module ucc_decode (
   input  logic [7:0]        data_byte,
   output ucc_pkg::lead_type lead
);
   import ucc_pkg::*;

   logic [LenWidth-1:0] len;
   logic [7:0]          mask;

   always_comb begin
      if (data_byte >= LEAD_MULTI) begin
         len = high_len(data_byte[4:0]);
      end else if (data_byte >= LEAD_TWO) begin
         len = 3'd2;
      end else begin
         len = 3'd1;
      end
   end

   always_comb begin
      unique case (len)
         3'd1:    mask = 8'hFF;
         3'd2:    mask = 8'h1F;
         3'd3:    mask = 8'h0F;
         3'd4:    mask = 8'h07;
         3'd5:    mask = 8'h03;
         default: mask = 8'h01;
      endcase
   end

   assign lead.len    = len;
   assign lead.single = (len == 3'd1);
   assign lead.point  = {{(PointWidth-8){1'b0}}, data_byte & mask};

endmodule

[rtl/utf8_codepoint_compare.sv]
`timescale 1ns / 1ps
// A result item is registered in the cycle after its request item is accepted.
// Throughput: one item per cycle while rsp_tready keeps up; decode, accumulate and
// subtract fit between the comparison state registers and the result register.
// A finish item clears the comparison state for the next pair of strings.
// Synchronous active-high reset clears all state and empties the result register.
module utf8_codepoint_compare (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_byte[7:0], first_has_more[8], second_has_more[9]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // want_side[0], decided[1], difference[33:2], malformed[34]
   output logic        rsp_tlast   // finished
);
   import ucc_pkg::*;

   logic                  expect_ff, expect_in;
   logic [LenWidth-1:0]   left_ff, left_in;
   logic [PointWidth-1:0] first_ff, first_in;
   logic [PointWidth-1:0] second_ff, second_in;
   logic                  decided_ff, decided_in;
   logic [DiffWidth-1:0]  held_ff, held_in;
   logic                  err_ff, err_in;

   logic                  rsp_valid_ff;
   logic [39:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic [1:0]            action;
   logic [7:0]            data_byte;
   logic                  first_more;
   logic                  second_more;
   logic                  side;
   lead_type              lead;

   logic [PointWidth-1:0] cont_point;
   logic [PointWidth-1:0] cmp_first;
   logic [PointWidth-1:0] cmp_second;
   logic                  do_cmp;
   logic [DiffWidth-1:0]  diff;
   logic [DiffWidth-1:0]  result;

   assign action      = req_tuser;
   assign data_byte   = req_tdata[7:0];
   assign first_more  = req_tdata[8];
   assign second_more = req_tdata[9];
   assign side        = action[0];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ucc_decode u_decode (
      .data_byte(data_byte),
      .lead     (lead)
   );

   assign cont_point = expect_ff ? {second_ff[PointWidth-7:0], data_byte[5:0]}
                                 : {first_ff[PointWidth-7:0], data_byte[5:0]};

   // Choose what gets compared when a second-string character closes.
   always_comb begin
      cmp_first  = first_ff;
      cmp_second = second_ff;
      do_cmp     = 1'b0;
      if (action >= ACT_FINISH) begin
         do_cmp = (left_ff != '0) && !decided_ff && expect_ff;
      end else if (!decided_ff) begin
         if (left_ff != '0) begin
            if (side == expect_ff) begin
               cmp_second = cont_point;
               do_cmp     = expect_ff && (left_ff == 3'd1);
            end else if (expect_ff) begin
               do_cmp = 1'b1;
            end else begin
               cmp_second = lead.point;
               do_cmp     = lead.single;
            end
         end else if (side == expect_ff && expect_ff) begin
            cmp_second = lead.point;
            do_cmp     = lead.single;
         end
      end
   end

   assign diff = {1'b0, cmp_first} - {1'b0, cmp_second};

   always_comb begin
      expect_in  = expect_ff;
      left_in    = left_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      decided_in = decided_ff;
      held_in    = held_ff;
      err_in     = err_ff;
      result     = held_ff;

      if (do_cmp && diff != '0) begin
         decided_in = 1'b1;
         held_in    = diff;
      end

      if (action >= ACT_FINISH) begin
         if (left_ff != '0 && !decided_ff) begin
            err_in = 1'b1;
         end
         result = held_in;
         if (result == '0) begin
            if (first_more) begin
               result = PLUS_ONE;
            end else if (second_more) begin
               result = MINUS_ONE;
            end
         end
      end else if (!decided_ff) begin
         if (left_ff != '0 && side == expect_ff) begin
            if (data_byte[7:6] != CONT_TAG) begin
               err_in = 1'b1;
            end
            if (expect_ff) begin
               second_in = cont_point;
            end else begin
               first_in = cont_point;
            end
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd1) begin
               expect_in = !expect_ff;
            end
         end else if (left_ff != '0 || side == expect_ff) begin
            // Either a fresh character on the expected side, or the other side
            // cuts the open character short and starts its own.
            if (left_ff != '0) begin
               err_in = 1'b1;
            end
            if (side) begin
               second_in = lead.point;
               if (lead.single) begin
                  expect_in = 1'b0;
                  left_in   = '0;
               end else begin
                  expect_in = 1'b1;
                  left_in   = lead.len - 3'd1;
               end
            end else begin
               expect_in = 1'b0;
               left_in   = '0;
               if (!(do_cmp && diff != '0)) begin
                  first_in = lead.point;
                  if (lead.single) begin
                     expect_in = 1'b1;
                  end else begin
                     left_in = lead.len - 3'd1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (action >= ACT_FINISH) begin
         rsp_data_in = {5'd0, err_in, result, (result != '0), 1'b0};
         rsp_last_in = 1'b1;
      end else begin
         rsp_data_in = {5'd0, err_in, held_in, decided_in, expect_in};
         rsp_last_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff  <= 1'b0;
         left_ff    <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         decided_ff <= 1'b0;
         held_ff    <= '0;
         err_ff     <= 1'b0;
      end else if (accept) begin
         if (action >= ACT_FINISH) begin
            expect_ff  <= 1'b0;
            left_ff    <= '0;
            first_ff   <= '0;
            second_ff  <= '0;
            decided_ff <= 1'b0;
            held_ff    <= '0;
            err_ff     <= 1'b0;
         end else begin
            expect_ff  <= expect_in;
            left_ff    <= left_in;
            first_ff   <= first_in;
            second_ff  <= second_in;
            decided_ff <= decided_in;
            held_ff    <= held_in;
            err_ff     <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      accept && action >= ACT_FINISH |=>
         left_ff == '0 && !decided_ff && !expect_ff && !err_ff && held_ff == '0)
      else $error("comparison state not cleared after finish item");

   a_decided_nonzero: assert property (@(posedge clock) disable iff (reset)
      decided_ff |-> held_ff != '0)
      else $error("decided without a nonzero difference");

   a_decided_holds: assert property (@(posedge clock) disable iff (reset)
      accept && action < ACT_FINISH && decided_ff |=>
         decided_ff && $stable(held_ff) && $stable(left_ff))
      else $error("byte item changed state after decision");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      accept && action < ACT_FINISH |=> left_ff <= 3'd5)
      else $error("continuation count out of range");

endmodule

[tb/sv/tb_utf8_codepoint_compare.sv]
`timescale 1ns / 1ps
module tb_utf8_codepoint_compare;
   import ucc_pkg::*;

   localparam logic [1:0] ActFinishAlias = 2'd3;
   localparam int RandomItems = 700;
   localparam int DirectedRows = 26;

   typedef struct packed {
      logic                 want_side;
      logic                 decided;
      logic [DiffWidth-1:0] difference;
      logic                 malformed;
      logic                 finished;
   } verdict_type;

   typedef struct {
      logic        typed;
      verdict_type res;
   } fixed_verdict_type;

   typedef struct {
      logic [1:0]  act;
      logic [7:0]  data;
      logic        first_more;
      logic        second_more;
      logic        typed;
      verdict_type res;
   } byte_row_type;

   typedef logic [7:0] char_bytes_type [$];

   typedef enum logic [1:0] {RspAlways, RspRandom, RspSparse, RspPeriodic} rsp_pace_type;
   typedef enum int {FaultNone, FaultBadCont, FaultTruncFirst, FaultTruncSecond,
                     FaultWrongSide} fault_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // data_byte[7:0], first_has_more[8], second_has_more[9]
   logic [1:0]  req_tuser;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // want_side[0], decided[1], difference[33:2], malformed[34]
   logic        rsp_tlast;   // finished

   // Predicted comparison state.
   logic                  pend_second;
   logic [LenWidth-1:0]   left_cnt;
   logic [PointWidth-1:0] first_cp;
   logic [PointWidth-1:0] second_cp;
   logic                  diff_found;
   logic [DiffWidth-1:0]  diff_held;
   logic                  bad_seen;

   verdict_type       pending_verdicts [$];
   fixed_verdict_type fixed_verdicts [$];
   byte_row_type      directed_rows [DirectedRows];
   int                fail_count = 0;
   int                items_sent = 0;
   int                burst_left = 0;
   rsp_pace_type      pace = RspAlways;
   int unsigned       pace_cycle = 0;

   utf8_codepoint_compare u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_compare();
      pend_second = 1'b0;
      left_cnt    = '0;
      first_cp    = '0;
      second_cp   = '0;
      diff_found  = 1'b0;
      diff_held   = '0;
      bad_seen    = 1'b0;
   endfunction

   function automatic void end_char();
      logic [DiffWidth-1:0] d;
      left_cnt = '0;
      if (!pend_second) begin
         pend_second = 1'b1;
      end else begin
         d = {1'b0, first_cp} - {1'b0, second_cp};
         if (d != '0) begin
            diff_found = 1'b1;
            diff_held  = d;
         end
         pend_second = 1'b0;
      end
   endfunction

   function automatic void begin_char(input logic [7:0] b);
      logic [LenWidth-1:0]   len;
      logic [PointWidth-1:0] cp;
      if (b >= 8'hFC) len = 3'd6;
      else if (b >= 8'hF8) len = 3'd5;
      else if (b >= 8'hF0) len = 3'd4;
      else if (b >= 8'hE0) len = 3'd3;
      else if (b >= 8'hC0) len = 3'd2;
      else len = 3'd1;
      if (len == 3'd1) cp = {23'd0, b};
      else cp = {23'd0, b & (8'h1F >> (len - 3'd2))};
      if (pend_second) second_cp = cp;
      else first_cp = cp;
      left_cnt = len - 3'd1;
      if (left_cnt == '0) end_char();
   endfunction

   function automatic verdict_type decode_and_compare(input logic [1:0] act,
                                                      input logic [7:0] b,
                                                      input logic first_more,
                                                      input logic second_more);
      verdict_type          r;
      logic [DiffWidth-1:0] final_diff;
      logic                 side;
      if (act == ACT_FINISH || act == ActFinishAlias) begin
         if (left_cnt != '0 && !diff_found) begin
            bad_seen = 1'b1;
            end_char();
         end
         final_diff = diff_held;
         if (final_diff == '0) begin
            if (first_more) final_diff = PLUS_ONE;
            else if (second_more) final_diff = MINUS_ONE;
         end
         r = '{1'b0, final_diff != '0, final_diff, bad_seen, 1'b1};
         clear_compare();
         return r;
      end
      if (!diff_found) begin
         side = (act == ACT_SECOND);
         if (left_cnt != '0) begin
            if (side != pend_second) begin
               bad_seen = 1'b1;
               end_char();
               if (!diff_found) begin_char(b);
            end else begin
               if (b[7:6] != CONT_TAG) bad_seen = 1'b1;
               if (pend_second) second_cp = {second_cp[PointWidth-7:0], b[5:0]};
               else first_cp = {first_cp[PointWidth-7:0], b[5:0]};
               left_cnt = left_cnt - 3'd1;
               if (left_cnt == '0) end_char();
            end
         end else if (side == pend_second) begin
            begin_char(b);
         end
      end
      r = '{pend_second, diff_found, diff_held, bad_seen, 1'b0};
      return r;
   endfunction

   task automatic check_field(input string name, input logic [DiffWidth-1:0] want,
                              input logic [DiffWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type       want_v;
      verdict_type       got_v;
      fixed_verdict_type fixed;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            fixed  = fixed_verdicts.pop_front();
            want_v = decode_and_compare(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9]);
            if (fixed.typed) want_v = fixed.res;
            pending_verdicts.push_back(want_v);
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got_v = '{rsp_tdata[0], rsp_tdata[1], rsp_tdata[33:2], rsp_tdata[34], rsp_tlast};
            if (pending_verdicts.size() == 0) begin
               $error("result item with no outstanding request");
               fail_count++;
            end else begin
               want_v = pending_verdicts.pop_front();
               check_field("want_side", 32'(want_v.want_side), 32'(got_v.want_side));
               check_field("decided", 32'(want_v.decided), 32'(got_v.decided));
               check_field("difference", want_v.difference, got_v.difference);
               check_field("malformed", 32'(want_v.malformed), 32'(got_v.malformed));
               check_field("finished", 32'(want_v.finished), 32'(got_v.finished));
            end
         end
      end
   end

   always @(posedge clock) begin
      pace_cycle++;
      if (pace_cycle % 48 == 0) pace = rsp_pace_type'($urandom_range(0, 3));
      case (pace)
         RspAlways:  rsp_tready <= 1'b1;
         RspRandom:  rsp_tready <= 1'($urandom_range(0, 1));
         RspSparse:  rsp_tready <= ($urandom_range(0, 3) == 0);
         default:    rsp_tready <= pace_cycle[1];
      endcase
   end

   task automatic push_item(input logic [1:0] act, input logic [7:0] data,
                            input logic first_more, input logic second_more,
                            input logic typed, input verdict_type res);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      fixed_verdicts.push_back('{typed, res});
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'd0, second_more, first_more, data};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic push_char(input logic [1:0] act, input char_bytes_type q);
      foreach (q[i]) push_item(act, q[i], 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   function automatic char_bytes_type make_char();
      char_bytes_type q;
      int             len;
      logic [7:0]     lead;
      len = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 6);
      case (len)
         1:       lead = 8'($urandom_range(8'h00, 8'hBF));
         2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
         3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
         4:       lead = 8'($urandom_range(8'hF0, 8'hF7));
         5:       lead = 8'($urandom_range(8'hF8, 8'hFB));
         default: lead = 8'($urandom_range(8'hFC, 8'hFF));
      endcase
      q.push_back(lead);
      for (int i = 1; i < len; i++) q.push_back(8'h80 | 8'($urandom_range(0, 63)));
      return q;
   endfunction

   function automatic logic [7:0] non_cont_byte();
      int v;
      v = $urandom_range(0, 191);
      return 8'(v >= 128 ? v + 64 : v);
   endfunction

   task automatic random_comparison();
      int             pairs;
      fault_type      fault;
      logic           differ;
      char_bytes_type q1;
      char_bytes_type q2;
      logic [1:0]     fin_act;
      pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
      for (int p = 0; p < pairs; p++) begin
         q1     = make_char();
         differ = ($urandom_range(0, 4) == 0);
         q2     = differ ? make_char() : q1;
         fault  = ($urandom_range(0, 9) == 0) ? fault_type'($urandom_range(1, 4)) : FaultNone;
         case (fault)
            FaultBadCont: begin
               if (q1.size() > 1) q1[$urandom_range(1, q1.size() - 1)] = non_cont_byte();
            end
            FaultTruncFirst: begin
               if (q1.size() > 1) void'(q1.pop_back());
            end
            FaultTruncSecond: begin
               if (q2.size() > 1) void'(q2.pop_back());
            end
            FaultWrongSide: begin
               push_item(ACT_SECOND, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            end
            default: ;
         endcase
         push_char(ACT_FIRST, q1);
         push_char(ACT_SECOND, q2);
         if (differ) break;
      end
      if ($urandom_range(0, 5) == 0) begin
         q1 = make_char();
         if (q1.size() > 1) void'(q1.pop_back());
         push_char(ACT_FIRST, q1);
      end
      fin_act = ($urandom_range(0, 7) == 0) ? ActFinishAlias : ACT_FINISH;
      push_item(fin_act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_FIRST;
      clear_compare();
      directed_rows = '{
         '{ACT_FIRST,      8'h41, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0}},
         '{ACT_SECOND,     8'h41, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
         '{ACT_FINISH,     8'h00, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b1, PLUS_ONE, 1'b0, 1'b1}},
         '{ACT_FINISH,     8'h00, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, MINUS_ONE, 1'b0, 1'b1}},
         '{ACT_FINISH,     8'h00, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 1'b1}},
         '{ACT_FINISH,     8'hFF, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b1, PLUS_ONE, 1'b0, 1'b1}},
         '{ActFinishAlias, 8'hFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 1'b1}},
         '{ACT_FIRST,      8'h00, 1'b1, 1'b1, 1'b0, '0},
         '{ACT_SECOND,     8'hFF, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'hBF, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'hBF, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'hBF, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'hBF, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'hBF, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FIRST,      8'h41, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FINISH,     8'h00, 1'b1, 1'b0, 1'b0, '0},
         '{ACT_FIRST,      8'h80, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'h80, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FIRST,      8'hC3, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FIRST,      8'h41, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'hE2, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FIRST,      8'h80, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FINISH,     8'h00, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_SECOND,     8'h41, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FIRST,      8'hF0, 1'b0, 1'b0, 1'b0, '0},
         '{ACT_FINISH,     8'h00, 1'b0, 1'b1, 1'b0, '0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].first_more,
                   directed_rows[i].second_more, directed_rows[i].typed, directed_rows[i].res);

      items_sent = 0;
      while (items_sent < RandomItems) random_comparison();

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0 && pending_verdicts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
rtl/ucc_pkg.sv
rtl/ucc_decode.sv
rtl/utf8_codepoint_compare.sv
tb/sv/tb_utf8_codepoint_compare.sv
